FILE: sv/pwde_pkg.sv
`timescale 1ns / 1ps
// pwde_pkg: shared widths, result kinds and cell control type
package pwde_pkg;

  localparam int DICT_ENTRIES = 10;
  localparam int PW_W         = 18;
  localparam int IDX_W        = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(DICT_ENTRIES + 1);

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_WIDTH  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;   // capture the probe width
    logic shift;  // take the neighbor's width
    logic live;   // entry lies below the fill count
  } cell_ctl_t;

endpackage

FILE: sv/pwde_ifs.sv
`timescale 1ns / 1ps
// pwde_in_if / pwde_out_if: valid/ready channels for pulses and results
interface pwde_in_if;
  logic                        valid;
  logic                        ready;
  logic [pwde_pkg::PW_W-1:0]   pulse_width;
  logic                        train_end;

  modport source (output valid, output pulse_width, output train_end, input ready);
  modport sink   (input valid, input pulse_width, input train_end, output ready);
endinterface

interface pwde_out_if;
  logic                        valid;
  logic                        ready;
  pwde_pkg::kind_t             kind;
  logic [pwde_pkg::PW_W-1:0]   value;
  logic                        run_last;

  modport source (output valid, output kind, output value, output run_last, input ready);
  modport sink   (input valid, input kind, input value, input run_last, output ready);
endinterface

FILE: sv/pulse_width_dictionary_encoder_unit.sv
`timescale 1ns / 1ps
// pulse_width_dictionary_encoder_unit: top level, cell row plus sequencer
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------
//   in_ch   | in  | valid/ready        | pulse_width[17:0], train_end
//   out_ch  | out | valid/ready        | kind[1:0], value[17:0], run_last
//
// a pulse that is not the last of its train is taken whenever the registered
// result slot is free; the slot is refilled in the same cycle it is drained
// after a last pulse that does not overflow, the cell row shifts toward cell 0
// once per cycle while the slot is free; cell 0 feeds the result register
// input ready drops while the row dumps and while a result waits unaccepted
// rst_n (synchronous) clears fill count, overflow flag, state and result valid;
// the cell widths are not reset
module pulse_width_dictionary_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  pwde_in_if.sink    in_ch,
  pwde_out_if.source out_ch
);

  localparam int N = pwde_pkg::DICT_ENTRIES;

  typedef enum logic {
    ST_RUN,
    ST_DUMP
  } state_t;

  state_t                         state_r;
  logic [pwde_pkg::CNT_W-1:0]     count_r;
  logic                           ovf_r;

  logic                           out_valid_r;
  pwde_pkg::kind_t                out_kind_r;
  logic [pwde_pkg::PW_W-1:0]      out_value_r;
  logic                           out_last_r;

  // cell row
  pwde_pkg::cell_ctl_t            ctl     [N];
  logic [pwde_pkg::PW_W-1:0]      cell_w  [N];
  logic [N-1:0]                   hit;

  logic                           slot_free;
  logic                           accept;
  logic                           any_hit;
  logic [pwde_pkg::IDX_W-1:0]     hit_idx;
  logic                           full;
  logic                           add_entry;
  logic                           dump_step;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_RUN) && slot_free;
  assign accept = in_ch.valid && in_ch.ready;

  // lowest matching entry wins
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = pwde_pkg::IDX_W'(i);
      end
    end
  end

  assign full      = (count_r == pwde_pkg::CNT_W'(N));
  assign add_entry = accept && !ovf_r && !any_hit && !full;
  assign dump_step = (state_r == ST_DUMP) && slot_free;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [pwde_pkg::PW_W-1:0] nbr_w;

    if (g == N - 1) begin : g_tail
      assign nbr_w = '0;
    end else begin : g_link
      assign nbr_w = cell_w[g+1];
    end

    always_comb begin
      ctl[g].load  = add_entry && (count_r == pwde_pkg::CNT_W'(g));
      ctl[g].shift = dump_step;
      ctl[g].live  = (count_r > pwde_pkg::CNT_W'(g));
    end

    pwde_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .probe      (in_ch.pulse_width),
      .next_width (nbr_w),
      .width      (cell_w[g]),
      .hit        (hit[g])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_RUN: begin
          if (accept) begin
            if (ovf_r) begin
              // rest of an overflowed train is dropped until its last pulse
              if (in_ch.train_end) begin
                count_r <= '0;
                ovf_r   <= 1'b0;
              end
            end else if (any_hit || !full) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= pwde_pkg::KIND_SYMBOL;
              out_value_r <= any_hit ? pwde_pkg::PW_W'(hit_idx)
                                     : pwde_pkg::PW_W'(count_r);
              out_last_r  <= !in_ch.train_end;
              if (!any_hit) begin
                count_r <= count_r + 1'b1;
              end
              if (in_ch.train_end) begin
                state_r <= ST_DUMP;
              end
            end else begin
              // one distinct width too many
              out_valid_r <= 1'b1;
              out_kind_r  <= pwde_pkg::KIND_ERROR;
              out_value_r <= '0;
              out_last_r  <= 1'b1;
              if (in_ch.train_end) begin
                count_r <= '0;
              end else begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        ST_DUMP: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= pwde_pkg::KIND_WIDTH;
            out_value_r <= cell_w[0];
            out_last_r  <= (count_r == pwde_pkg::CNT_W'(1));
            count_r     <= count_r - 1'b1;
            if (count_r == pwde_pkg::CNT_W'(1)) begin
              state_r <= ST_RUN;
            end
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.run_last = out_last_r;

endmodule

FILE: sv/pwde_cell.sv
`timescale 1ns / 1ps
// pwde_cell: one dictionary entry with its match compare and shift link
module pwde_cell (
  input  logic                        clk,
  input  pwde_pkg::cell_ctl_t         ctl,
  input  logic [pwde_pkg::PW_W-1:0]   probe,
  input  logic [pwde_pkg::PW_W-1:0]   next_width,
  output logic [pwde_pkg::PW_W-1:0]   width,
  output logic                        hit
);

  logic [pwde_pkg::PW_W-1:0] width_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      width_r <= probe;
    end else if (ctl.shift) begin
      width_r <= next_width;
    end
  end

  assign width = width_r;
  assign hit   = ctl.live && (width_r == probe);

endmodule

FILE: sv/pwde_chk.sv
`timescale 1ns / 1ps
// pwde_chk: port-level checks for the encoder, bound to the top level
module pwde_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [pwde_pkg::PW_W-1:0]   out_value,
  input logic                        out_run_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind)
      && $stable(out_run_last))
    else $error("stalled result changed");

  // error item is a single result with value zero
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == pwde_pkg::KIND_ERROR) |-> out_run_last && (out_value == '0))
    else $error("malformed overflow result");

  // symbols index the dictionary
  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == pwde_pkg::KIND_SYMBOL)
      |-> out_value < pwde_pkg::PW_W'(pwde_pkg::DICT_ENTRIES))
    else $error("symbol index out of range");

  // while the dictionary is dumped no pulse is taken
  a_dump_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == pwde_pkg::KIND_WIDTH) && !out_run_last
      |-> !in_ready)
    else $error("pulse taken during dictionary dump");

  // a symbol that is not last is always followed by a dictionary value
  a_sym_then_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == pwde_pkg::KIND_SYMBOL) && !out_run_last
      |=> out_valid && (out_kind == pwde_pkg::KIND_WIDTH))
    else $error("dictionary dump missing after last pulse");

endmodule

bind pulse_width_dictionary_encoder_unit pwde_chk u_pwde_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_value    (out_ch.value),
  .out_run_last (out_ch.run_last)
);
